// File: src/ihg_pkg.sv
// Shared constants and types for the IPv4 header generator.
package ihg_pkg;

  localparam int unsigned HeaderBytes = 20;
  localparam int unsigned IdxW        = 5;
  localparam int unsigned CfgIdxW     = 3;
  localparam int unsigned CfgDataW    = 32;
  localparam int unsigned SumW        = 20;  // ten 16-bit words fit in 20 bits

  localparam logic [15:0] MaxPayload  = 16'd65515;
  localparam logic [IdxW-1:0] LastIdx = IdxW'(HeaderBytes - 1);

  localparam logic [7:0]  RstVersionIhl = 8'h45;
  localparam logic [7:0]  RstService    = 8'h00;
  localparam logic [15:0] RstIdent      = 16'h0212;
  localparam logic [15:0] RstFlagsFrag  = 16'h0000;
  localparam logic [7:0]  RstTtl        = 8'hFF;
  localparam logic [7:0]  RstProtocol   = 8'h11;
  localparam logic [31:0] RstSrcAddr    = 32'h0000_0000;
  localparam logic [31:0] RstDstAddr    = 32'hFFFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    RegVersionIhl  = 3'd0,
    RegService     = 3'd1,
    RegIdent       = 3'd2,
    RegFlagsFrag   = 3'd3,
    RegTtl         = 3'd4,
    RegProtocol    = 3'd5,
    RegSrcAddr     = 3'd6,
    RegDstAddr     = 3'd7
  } cfg_reg_e;

endpackage

// File: src/ipv4_header_generator.sv
// IPv4 header generator: one request in, twenty header bytes out.
//
//  channel   | handshake                  | payload
//  ----------+----------------------------+------------------------------------------
//  request   | start (in), busy (out)     | payload_length_i[15:0]
//  result    | result_valid_o (strobe)    | header_byte_o[7:0], byte_index_o[4:0],
//            |                            | last_byte_o
//  config    | cfg_we_i                   | cfg_idx_i[2:0], cfg_wdata_i[31:0]
//
//  A request is taken when start is high and busy is low. It lands in a one-deep
//  request register holding the clamped total length; busy is that register's
//  full flag, so a new request is taken while the previous header is still going out.
//  The header is sent at one byte per cycle; the byte-wide result port sets that rate.
//  Back-to-back requests give a gapless byte stream. When the emitter is idle, a new
//  request goes through the request and emitter registers, then the result register.
//  Reset clears control state and loads the header registers with their defaults.
//  Results cannot be stalled; the strobe marks each byte for exactly one cycle.
module ipv4_header_generator
  import ihg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // request
  input  logic                start,
  output logic                busy,
  input  logic [15:0]         payload_length_i,
  // result
  output logic                result_valid_o,
  output logic [7:0]          header_byte_o,
  output logic [IdxW-1:0]     byte_index_o,
  output logic                last_byte_o,
  // configuration
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i
);

  // configuration registers
  logic [7:0]  version_ihl_q, service_type_q, time_to_live_q, protocol_number_q;
  logic [15:0] ident_value_q, flags_fragment_q;
  logic [31:0] source_address_q, dest_address_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      version_ihl_q     <= RstVersionIhl;
      service_type_q    <= RstService;
      ident_value_q     <= RstIdent;
      flags_fragment_q  <= RstFlagsFrag;
      time_to_live_q    <= RstTtl;
      protocol_number_q <= RstProtocol;
      source_address_q  <= RstSrcAddr;
      dest_address_q    <= RstDstAddr;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_idx_i))
        RegVersionIhl: version_ihl_q     <= cfg_wdata_i[7:0];
        RegService:    service_type_q    <= cfg_wdata_i[7:0];
        RegIdent:      ident_value_q     <= cfg_wdata_i[15:0];
        RegFlagsFrag:  flags_fragment_q  <= cfg_wdata_i[15:0];
        RegTtl:        time_to_live_q    <= cfg_wdata_i[7:0];
        RegProtocol:   protocol_number_q <= cfg_wdata_i[7:0];
        RegSrcAddr:    source_address_q  <= cfg_wdata_i;
        RegDstAddr:    dest_address_q    <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // request register: holds clamped total length until the emitter takes it
  logic        pend_valid_q, pend_valid_d;
  logic [15:0] pend_len_q, pend_len_d;
  logic        accept, load;

  // emitter state
  logic            act_q, act_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [15:0]     tot_len_q, tot_len_d;
  logic [15:0]     csum_q, csum_d;

  assign busy   = pend_valid_q;
  assign accept = start && !pend_valid_q;
  // emitter frees up after its last byte, so the next header follows without a gap
  assign load   = pend_valid_q && (!act_q || (idx_q == LastIdx));

  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_len_d   = pend_len_q;
    if (accept) begin
      pend_valid_d = 1'b1;
      // oversized payloads saturate total length at 0xFFFF
      pend_len_d   = ((payload_length_i > MaxPayload) ? MaxPayload : payload_length_i)
                     + 16'(HeaderBytes);
    end else if (load) begin
      pend_valid_d = 1'b0;
    end
  end

  // checksum over the header words with the checksum word as zero
  logic [SumW-1:0] sum_raw;
  logic [16:0]     sum_f1;
  logic [15:0]     sum_f2;

  always_comb begin
    sum_raw = SumW'({version_ihl_q, service_type_q})
            + SumW'(pend_len_q)
            + SumW'(ident_value_q)
            + SumW'(flags_fragment_q)
            + SumW'({time_to_live_q, protocol_number_q})
            + SumW'(source_address_q[31:16])
            + SumW'(source_address_q[15:0])
            + SumW'(dest_address_q[31:16])
            + SumW'(dest_address_q[15:0]);
    // two folds cover any carry out of a 20-bit sum
    sum_f1 = 17'(sum_raw[15:0]) + 17'(sum_raw[SumW-1:16]);
    sum_f2 = sum_f1[15:0] + 16'(sum_f1[16]);
  end

  always_comb begin
    act_d     = act_q;
    idx_d     = idx_q;
    tot_len_d = tot_len_q;
    csum_d    = csum_q;
    if (load) begin
      act_d     = 1'b1;
      idx_d     = '0;
      tot_len_d = pend_len_q;
      csum_d    = ~sum_f2;
    end else if (act_q) begin
      if (idx_q == LastIdx) begin
        act_d = 1'b0;
      end else begin
        idx_d = idx_q + IdxW'(1);
      end
    end
  end

  // byte select for the current position
  logic [7:0] byte_sel;

  always_comb begin
    case (idx_q)
      5'd0:    byte_sel = version_ihl_q;
      5'd1:    byte_sel = service_type_q;
      5'd2:    byte_sel = tot_len_q[15:8];
      5'd3:    byte_sel = tot_len_q[7:0];
      5'd4:    byte_sel = ident_value_q[15:8];
      5'd5:    byte_sel = ident_value_q[7:0];
      5'd6:    byte_sel = flags_fragment_q[15:8];
      5'd7:    byte_sel = flags_fragment_q[7:0];
      5'd8:    byte_sel = time_to_live_q;
      5'd9:    byte_sel = protocol_number_q;
      5'd10:   byte_sel = csum_q[15:8];
      5'd11:   byte_sel = csum_q[7:0];
      5'd12:   byte_sel = source_address_q[31:24];
      5'd13:   byte_sel = source_address_q[23:16];
      5'd14:   byte_sel = source_address_q[15:8];
      5'd15:   byte_sel = source_address_q[7:0];
      5'd16:   byte_sel = dest_address_q[31:24];
      5'd17:   byte_sel = dest_address_q[23:16];
      5'd18:   byte_sel = dest_address_q[15:8];
      5'd19:   byte_sel = dest_address_q[7:0];
      default: byte_sel = '0;
    endcase
  end

  // result register
  logic            out_valid_q;
  logic [7:0]      out_byte_q;
  logic [IdxW-1:0] out_idx_q;
  logic            out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      act_q        <= 1'b0;
      idx_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      pend_valid_q <= pend_valid_d;
      act_q        <= act_d;
      idx_q        <= idx_d;
      out_valid_q  <= act_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_len_q <= pend_len_d;
    tot_len_q  <= tot_len_d;
    csum_q     <= csum_d;
    out_byte_q <= byte_sel;
    out_idx_q  <= idx_q;
    out_last_q <= (idx_q == LastIdx);
  end

  assign result_valid_o = out_valid_q;
  assign header_byte_o  = out_byte_q;
  assign byte_index_o   = out_idx_q;
  assign last_byte_o    = out_valid_q && out_last_q;

endmodule

// File: src/ihg_checker.sv
// Port-level checks for the IPv4 header generator, bound to the top level.
module ihg_checker
  import ihg_pkg::*;
(
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input logic                result_valid_o,
  input logic [IdxW-1:0]     byte_index_o,
  input logic                last_byte_o
);

  // a header goes out without gaps
  a_no_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_byte_o |=> result_valid_o)
    else $error("gap inside header stream");

  // positions count up by one
  a_index_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o && !last_byte_o |=> byte_index_o == $past(byte_index_o) + 5'd1)
    else $error("byte index skipped");

  // last flag only on the final position
  a_last_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_byte_o |-> result_valid_o && byte_index_o == LastIdx)
    else $error("last flag on wrong byte");

  // an accepted request is held before it is sent
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("accepted request not held");

endmodule

bind ipv4_header_generator ihg_checker u_ihg_checker (.*);

// File: tb/ihg_header_checker.sv
// Checker for the IPv4 header generator: tracks registers, predicts header bytes, compares.
`timescale 1ns / 1ps

module ihg_header_checker
  import ihg_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic                busy_i,
  input  logic [15:0]         payload_length_i,
  input  logic                result_valid_i,
  input  logic [7:0]          header_byte_i,
  input  logic [IdxW-1:0]     byte_index_i,
  input  logic                last_byte_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  checked_o,
  output int                  pending_o
);

  typedef struct packed {
    logic [7:0]      hdr_byte;
    logic [IdxW-1:0] index;
    logic            last;
  } hdr_result_t;

  hdr_result_t expected_bytes_q[$];

  // local copy of the header registers
  logic [7:0]  ver_ihl_q;
  logic [7:0]  tos_q;
  logic [15:0] ident_q;
  logic [15:0] flags_frag_q;
  logic [7:0]  ttl_q;
  logic [7:0]  proto_q;
  logic [31:0] src_q;
  logic [31:0] dst_q;

  // Build the 20-byte header for one request and queue it byte by byte.
  task automatic queue_header(input logic [15:0] payload_len);
    logic [7:0]      hdr [HeaderBytes];
    logic [15:0]     total_len;
    logic [SumW-1:0] sum;
    logic [15:0]     csum;
    hdr_result_t     r;
    total_len = ((payload_len > MaxPayload) ? MaxPayload : payload_len) + 16'(HeaderBytes);
    hdr[0]  = ver_ihl_q;
    hdr[1]  = tos_q;
    hdr[2]  = total_len[15:8];
    hdr[3]  = total_len[7:0];
    hdr[4]  = ident_q[15:8];
    hdr[5]  = ident_q[7:0];
    hdr[6]  = flags_frag_q[15:8];
    hdr[7]  = flags_frag_q[7:0];
    hdr[8]  = ttl_q;
    hdr[9]  = proto_q;
    hdr[10] = 8'h00;
    hdr[11] = 8'h00;
    for (int k = 0; k < 4; k++) begin
      hdr[12+k] = src_q[31-8*k -: 8];
      hdr[16+k] = dst_q[31-8*k -: 8];
    end
    sum = '0;
    for (int k = 0; k < HeaderBytes; k += 2) sum += {hdr[k], hdr[k+1]};
    // two folds are enough for a 20-bit sum
    sum = sum[15:0] + sum[SumW-1:16];
    sum = sum[15:0] + sum[SumW-1:16];
    csum = ~sum[15:0];
    hdr[10] = csum[15:8];
    hdr[11] = csum[7:0];
    for (int k = 0; k < HeaderBytes; k++) begin
      r.hdr_byte = hdr[k];
      r.index    = IdxW'(k);
      r.last     = (k == HeaderBytes - 1);
      expected_bytes_q.push_back(r);
    end
  endtask

  function automatic int field_bad(input string name, input logic [31:0] exp_v,
                                   input logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s mismatch: expected %0h, got %0h", name, exp_v, act_v);
      return 1;
    end
    return 0;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ver_ihl_q    <= RstVersionIhl;
      tos_q        <= RstService;
      ident_q      <= RstIdent;
      flags_frag_q <= RstFlagsFrag;
      ttl_q        <= RstTtl;
      proto_q      <= RstProtocol;
      src_q        <= RstSrcAddr;
      dst_q        <= RstDstAddr;
      expected_bytes_q.delete();
      pending_o    <= 0;
    end else begin
      // pop before push: a byte seen at the accepting edge belongs to an older item
      if (result_valid_i) begin
        if (expected_bytes_q.size() == 0) begin
          $error("unexpected header byte %0h at index %0d", header_byte_i, byte_index_i);
          fail_count_o += 1;
        end else begin
          hdr_result_t exp_r;
          exp_r = expected_bytes_q.pop_front();
          fail_count_o += field_bad("header_byte", 32'(exp_r.hdr_byte), 32'(header_byte_i));
          fail_count_o += field_bad("byte_index", 32'(exp_r.index), 32'(byte_index_i));
          fail_count_o += field_bad("last_byte", 32'(exp_r.last), 32'(last_byte_i));
          checked_o += 1;
        end
      end
      if (start_i && !busy_i) queue_header(payload_length_i);
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_idx_i))
          RegVersionIhl: ver_ihl_q    <= cfg_wdata_i[7:0];
          RegService:    tos_q        <= cfg_wdata_i[7:0];
          RegIdent:      ident_q      <= cfg_wdata_i[15:0];
          RegFlagsFrag:  flags_frag_q <= cfg_wdata_i[15:0];
          RegTtl:        ttl_q        <= cfg_wdata_i[7:0];
          RegProtocol:   proto_q      <= cfg_wdata_i[7:0];
          RegSrcAddr:    src_q        <= cfg_wdata_i;
          RegDstAddr:    dst_q        <= cfg_wdata_i;
          default: ;
        endcase
      end
      pending_o <= expected_bytes_q.size();
    end
  end

  initial begin
    fail_count_o = 0;
    checked_o    = 0;
  end

endmodule

// File: tb/tb_ipv4_header_generator.sv
// Top-level testbench for the IPv4 header generator: stimulus, register phases, verdict.
`timescale 1ns / 1ps

module tb_ipv4_header_generator;
  import ihg_pkg::*;

  localparam int unsigned RandomItems = 330;
  // first byte passes the request, emitter and result registers, then one full header; pad a little
  localparam int unsigned TailCycles  = 30;
  localparam int unsigned MaxGap      = 10;

  typedef enum int {FillRandom, FillZero, FillOnes} reg_fill_e;

  typedef struct packed {
    logic [7:0]  ver_ihl;
    logic [7:0]  tos;
    logic [15:0] ident;
    logic [15:0] flags_frag;
    logic [7:0]  ttl;
    logic [7:0]  proto;
    logic [31:0] src;
    logic [31:0] dst;
  } hdr_cfg_t;

  logic                clk_i            = 1'b0;
  logic                rst_ni           = 1'b0;
  logic                start            = 1'b0;
  logic                busy;
  logic [15:0]         payload_length_i = '0;
  logic                result_valid_o;
  logic [7:0]          header_byte_o;
  logic [IdxW-1:0]     byte_index_o;
  logic                last_byte_o;
  logic                cfg_we_i         = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i        = '0;
  logic [CfgDataW-1:0] cfg_wdata_i      = '0;

  int fail_count;
  int bytes_checked;
  int bytes_pending;
  int requests_sent = 0;
  int reg_loads     = 0;
  bit idle_on       = 1'b1;

  ipv4_header_generator u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .payload_length_i (payload_length_i),
    .result_valid_o   (result_valid_o),
    .header_byte_o    (header_byte_o),
    .byte_index_o     (byte_index_o),
    .last_byte_o      (last_byte_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i)
  );

  ihg_header_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .payload_length_i (payload_length_i),
    .result_valid_i   (result_valid_o),
    .header_byte_i    (header_byte_o),
    .byte_index_i     (byte_index_o),
    .last_byte_i      (last_byte_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .fail_count_o     (fail_count),
    .checked_o        (bytes_checked),
    .pending_o        (bytes_pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Offer one request. Start stays high on return, so a back-to-back item
  // keeps it asserted without a glitch. Returns at the accepting edge.
  task automatic send_request(input logic [15:0] len);
    int gap;
    gap = idle_on ? $urandom_range(0, MaxGap) : 0;
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    payload_length_i <= len;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    requests_sent++;
  endtask

  // Stop sending and hold off until every queued header byte has come out.
  task automatic drain_results();
    start <= 1'b0;
    @(posedge clk_i);
    while (bytes_pending != 0) @(posedge clk_i);
  endtask

  // Write all eight registers back to back; narrow registers get junk in
  // the upper data bits, which the block must drop.
  task automatic load_regs(input hdr_cfg_t c);
    logic [31:0] junk;
    logic [31:0] wdata [8];
    junk = $urandom();
    wdata[RegVersionIhl] = {junk[31:8], c.ver_ihl};
    wdata[RegService]    = {~junk[31:8], c.tos};
    wdata[RegIdent]      = {junk[15:0], c.ident};
    wdata[RegFlagsFrag]  = {~junk[15:0], c.flags_frag};
    wdata[RegTtl]        = {junk[23:0], c.ttl};
    wdata[RegProtocol]   = {~junk[23:0], c.proto};
    wdata[RegSrcAddr]    = c.src;
    wdata[RegDstAddr]    = c.dst;
    for (int i = 0; i < 8; i++) begin
      cfg_we_i    <= 1'b1;
      cfg_idx_i   <= CfgIdxW'(i);
      cfg_wdata_i <= wdata[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    reg_loads++;
  endtask

  task automatic pick_regs(input reg_fill_e fill);
    hdr_cfg_t c;
    case (fill)
      FillZero: c = '0;
      FillOnes: c = '1;
      default: begin
        c = {$urandom(), $urandom(), $urandom(), $urandom()};
      end
    endcase
    load_regs(c);
  endtask

  function automatic logic [15:0] pick_length();
    case ($urandom_range(0, 7))
      0:       return 16'($urandom_range(65505, 65535));  // around the clamp
      1:       return 16'($urandom_range(0, 40));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  initial begin
    hdr_cfg_t    mixed;
    logic [15:0] dir_lens [10];
    int          phase_len;
    reg_fill_e   fill;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset register values, length extremes and the clamp edge.
    dir_lens = '{16'd0, 16'd1, 16'd19, 16'd20, 16'd65514, 16'd65515, 16'd65516,
                 16'd65535, 16'h5555, 16'hAAAA};
    foreach (dir_lens[i]) send_request(dir_lens[i]);
    drain_results();

    // all-zero registers: checksum of just the length
    pick_regs(FillZero);
    send_request(16'd0);
    send_request(16'd65535);
    send_request(16'h8000);
    drain_results();

    // all-ones registers: maximum carries through the fold
    pick_regs(FillOnes);
    send_request(16'd0);
    send_request(16'd65535);
    send_request(16'd12345);
    drain_results();

    // alternating patterns, no idling between items
    idle_on = 1'b0;
    mixed = '{8'h5A, 8'hA5, 16'hFFFF, 16'h4000, 8'h01, 8'h06, 32'hC0A8_0101, 32'h0A00_00FE};
    load_regs(mixed);
    send_request(16'd1480);
    send_request(16'd65515);
    send_request(16'd40);
    send_request(16'd0);
    drain_results();

    // Random phases: fresh registers each time, idling on or off per phase.
    while (requests_sent < 20 + RandomItems) begin
      case ($urandom_range(0, 5))
        0:       fill = FillZero;
        1:       fill = FillOnes;
        default: fill = FillRandom;
      endcase
      pick_regs(fill);
      idle_on   = ($urandom_range(0, 3) != 0);
      phase_len = $urandom_range(8, 40);
      for (int i = 0; i < phase_len; i++) begin
        send_request(pick_length());
        // occasional full stop mid-phase
        if ($urandom_range(0, 24) == 0) drain_results();
      end
      drain_results();
    end

    repeat (TailCycles) @(posedge clk_i);

    $display("Run covered %0d requests over %0d register loads, %0d header bytes compared.",
             requests_sent, reg_loads + 1, bytes_checked);
    $display("Lengths spanned 0 to 65535 across the clamp; registers at zero, ones and random.");
    if (fail_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // watchdog: far beyond the slowest legal run
  initial begin
    #5_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
